[hdl/ray_triangle_intersect_assert.svh]
// ============================================================================
// ray triangle intersect assertion macros
// shared property shapes for the checks at the end of the top level
// ============================================================================
`ifndef RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off while in reset
`define RTI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rti check failed");

// next-cycle implication, clocked on clk_i, off while in reset
`define RTI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rti check failed");

`endif

[hdl/rti_pkg.sv]
// ============================================================================
// rti_pkg
// shared types and constants of the ray triangle intersect block
// ============================================================================
package rti_pkg;

  // threshold register width, fixed by its scaling
  localparam int unsigned THRESH_W = 41;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DET_TH   = 3'd6;

  // threshold reset, about 1e-9 in units of 2^-48
  localparam logic [THRESH_W-1:0] DET_TH_RESET = 41'd281475;

  // miss reason codes
  typedef enum logic [1:0] {
    MISS_NONE = 2'd0,
    MISS_DET  = 2'd1,
    MISS_U    = 2'd2,
    MISS_V    = 2'd3
  } miss_e;

  // stage control: advance enable and valid of the incoming request
  typedef struct packed {
    logic en;
    logic vld;
  } rti_pipe_t;

endpackage

[hdl/rti_edge.sv]
// ============================================================================
// rti_edge
// first stage: triangle edges and vertex0-to-origin vector
// ============================================================================
module rti_edge #(
  parameter int unsigned W = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rti_pkg::rti_pipe_t   ctrl_i,
  input  logic signed [W-1:0]  vtx_i [9],
  input  logic signed [W-1:0]  ori_i [3],
  output logic signed [W:0]    e1_o  [3],
  output logic signed [W:0]    e2_o  [3],
  output logic signed [W:0]    tv_o  [3],
  output logic                 vld_o
);
  import rti_pkg::*;

  logic signed [W:0] e1_d [3];
  logic signed [W:0] e2_d [3];
  logic signed [W:0] tv_d [3];
  logic signed [W:0] e1_q [3];
  logic signed [W:0] e2_q [3];
  logic signed [W:0] tv_q [3];
  logic              vld_q;

  // edge differences, one bit wider than a coordinate
  for (genvar k = 0; k < 3; k++) begin : g_axis
    assign e1_d[k] = (W+1)'(vtx_i[3+k]) - (W+1)'(vtx_i[k]);
    assign e2_d[k] = (W+1)'(vtx_i[6+k]) - (W+1)'(vtx_i[k]);
    assign tv_d[k] = (W+1)'(ori_i[k])   - (W+1)'(vtx_i[k]);
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      e1_q <= e1_d;
      e2_q <= e2_d;
      tv_q <= tv_d;
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.en) begin
      vld_q <= ctrl_i.vld;
    end
  end

  assign e1_o  = e1_q;
  assign e2_o  = e2_q;
  assign tv_o  = tv_q;
  assign vld_o = vld_q;

endmodule

[hdl/rti_cross.sv]
// ============================================================================
// rti_cross
// second stage: pvec = dir x e2 and qvec = tvec x e1
// ============================================================================
module rti_cross #(
  parameter int unsigned W = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rti_pkg::rti_pipe_t    ctrl_i,
  input  logic signed [W-1:0]   dir_i [3],
  input  logic signed [W:0]     e1_i  [3],
  input  logic signed [W:0]     e2_i  [3],
  input  logic signed [W:0]     tv_i  [3],
  output logic signed [2*W+2:0] pv_o  [3],
  output logic signed [2*W+2:0] qv_o  [3],
  output logic signed [W:0]     e1_o  [3],
  output logic signed [W:0]     tv_o  [3],
  output logic                  vld_o
);
  import rti_pkg::*;

  localparam int unsigned PW = 2*W + 3;
  localparam int unsigned MW = 2*W + 2;

  logic signed [W:0]    dx   [3];
  logic signed [PW-1:0] pv_d [3];
  logic signed [PW-1:0] qv_d [3];
  logic signed [PW-1:0] pv_q [3];
  logic signed [PW-1:0] qv_q [3];
  logic signed [W:0]    e1_q [3];
  logic signed [W:0]    tv_q [3];
  logic                 vld_q;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;
    logic signed [MW-1:0] pa, pb, qa, qb;

    assign dx[k] = (W+1)'(dir_i[k]);

    // cross product terms, exact at 2W+2 bits
    assign pa = dx[K1] * e2_i[K2];
    assign pb = dx[K2] * e2_i[K1];
    assign qa = tv_i[K1] * e1_i[K2];
    assign qb = tv_i[K2] * e1_i[K1];

    assign pv_d[k] = PW'(pa) - PW'(pb);
    assign qv_d[k] = PW'(qa) - PW'(qb);
  end

  // payload registers, e1 and tvec carried along for the dot stage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      pv_q <= pv_d;
      qv_q <= qv_d;
      e1_q <= e1_i;
      tv_q <= tv_i;
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctrl_i.en) begin
      vld_q <= ctrl_i.vld;
    end
  end

  assign pv_o  = pv_q;
  assign qv_o  = qv_q;
  assign e1_o  = e1_q;
  assign tv_o  = tv_q;
  assign vld_o = vld_q;

endmodule

[hdl/rti_dot.sv]
// ============================================================================
// rti_dot
// two-stage dot product of a short and a long vector, long operand split
// ============================================================================
module rti_dot #(
  parameter int unsigned W = 24
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [W:0]     a_i [3],
  input  logic signed [2*W+2:0] p_i [3],
  output logic signed [3*W+5:0] dot_o
);
  import rti_pkg::*;

  localparam int unsigned PW  = 2*W + 3;
  localparam int unsigned LO  = W + 2;
  localparam int unsigned DW  = 3*W + 6;
  localparam int unsigned PLW = 2*W + 4;
  localparam int unsigned PHW = 2*W + 2;
  localparam int unsigned SLW = 2*W + 6;
  localparam int unsigned SHW = 2*W + 4;

  logic signed [PLW-1:0] pl [3];
  logic signed [PHW-1:0] ph [3];
  logic signed [SLW-1:0] sum_lo_d, sum_lo_q;
  logic signed [SHW-1:0] sum_hi_d, sum_hi_q;
  logic signed [DW-1:0]  dot_d, dot_q;

  // partial products: low half as unsigned, high half signed
  for (genvar k = 0; k < 3; k++) begin : g_elem
    assign pl[k] = a_i[k] * $signed({1'b0, p_i[k][LO-1:0]});
    assign ph[k] = a_i[k] * $signed(p_i[k][PW-1:LO]);
  end

  assign sum_lo_d = SLW'(pl[0]) + SLW'(pl[1]) + SLW'(pl[2]);
  assign sum_hi_d = SHW'(ph[0]) + SHW'(ph[1]) + SHW'(ph[2]);

  // recombine the halves
  assign dot_d = (DW'(sum_hi_q) <<< LO) + DW'(sum_lo_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_lo_q <= sum_lo_d;
      sum_hi_q <= sum_hi_d;
      dot_q    <= dot_d;
    end
  end

  assign dot_o = dot_q;

endmodule

[hdl/ray_triangle_intersect.sv]
// ============================================================================
// ray_triangle_intersect
// one-sided ray/triangle hit test, fixed point, no division
// ============================================================================
// Usage:
//   The ray (origin, direction) and the det threshold are written through the
//   cfg channel (cfg_index_i selects the register, cfg_data_i carries it)
//   while no request is in flight; cfg_ready_o is always high.
//   Each request on the s_axis channel is one triangle of nine coordinates.
//   For each triangle one result leaves on m_axis: hit flag and miss reason.
//   Stages from accept to m_axis_tdata_o: edges, cross products, split dot
//   products, recombine, compare into the output register. One triangle is
//   taken every cycle unless the output stalls; the split dot product
//   multipliers and the 3W+6 bit recombine adder set the stage depth.
//   Reset clears all valid bits and loads the register defaults (origin at
//   zero, direction +z at 1.0, threshold about 1e-9).
//   When the receiver holds m_axis_tready_i low with a result waiting, the
//   whole pipe freezes and s_axis_tready_o drops in the same cycle; nothing
//   is lost or repeated.
// ============================================================================
module ray_triangle_intersect #(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // cfg channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [rti_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [rti_pkg::THRESH_W-1:0]          cfg_data_i,
  // triangle requests
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // vertex0_x, vertex0_y, vertex0_z, vertex1_x .. vertex2_z, COORD_WIDTH each
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata_i,
  // results
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // bit 0 hit, bits 2:1 miss_reason, rest zero
  output logic [7:0]                            m_axis_tdata_o
);
  import rti_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned PW = 2*W + 3;
  localparam int unsigned DW = 3*W + 6;

  // configuration registers
  logic signed [W-1:0]   ori_q [3];
  logic signed [W-1:0]   dir_q [3];
  logic [THRESH_W-1:0]   th_q;

  // pipeline signals
  logic                  adv;
  rti_pipe_t             ctrl0, ctrl1;
  logic signed [W-1:0]   vtx [9];
  logic signed [W:0]     e1_s1 [3];
  logic signed [W:0]     e2_s1 [3];
  logic signed [W:0]     tv_s1 [3];
  logic                  vld1;
  logic signed [PW-1:0]  pv_s2 [3];
  logic signed [PW-1:0]  qv_s2 [3];
  logic signed [W:0]     e1_s2 [3];
  logic signed [W:0]     tv_s2 [3];
  logic                  vld2;
  logic signed [W:0]     dx [3];
  logic                  vld3_q, vld4_q;
  logic signed [DW-1:0]  det, unum, vnum;
  logic signed [DW:0]    uv_sum;
  logic signed [DW-1:0]  th_ext;
  miss_e                 reason_d, reason_q;
  logic                  out_vld_q;

  // configuration write decode
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ori_q[0] <= '0;
      ori_q[1] <= '0;
      ori_q[2] <= '0;
      dir_q[0] <= '0;
      dir_q[1] <= '0;
      dir_q[2] <= W'(1) << FRAC_BITS;
      th_q     <= DET_TH_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ORIGIN_X: ori_q[0] <= cfg_data_i[W-1:0];
        REG_ORIGIN_Y: ori_q[1] <= cfg_data_i[W-1:0];
        REG_ORIGIN_Z: ori_q[2] <= cfg_data_i[W-1:0];
        REG_DIR_X:    dir_q[0] <= cfg_data_i[W-1:0];
        REG_DIR_Y:    dir_q[1] <= cfg_data_i[W-1:0];
        REG_DIR_Z:    dir_q[2] <= cfg_data_i[W-1:0];
        REG_DET_TH:   th_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: the pipe moves unless a result is held at the output
  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  for (genvar k = 0; k < 9; k++) begin : g_unpack
    assign vtx[k] = s_axis_tdata_i[k*W +: W];
  end

  assign ctrl0 = '{en: adv, vld: s_axis_tvalid_i};
  assign ctrl1 = '{en: adv, vld: vld1};

  // stage 1: edges and tvec
  rti_edge #(.W(W)) u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl0),
    .vtx_i  (vtx),
    .ori_i  (ori_q),
    .e1_o   (e1_s1),
    .e2_o   (e2_s1),
    .tv_o   (tv_s1),
    .vld_o  (vld1)
  );

  // stage 2: pvec and qvec
  rti_cross #(.W(W)) u_cross (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl1),
    .dir_i  (dir_q),
    .e1_i   (e1_s1),
    .e2_i   (e2_s1),
    .tv_i   (tv_s1),
    .pv_o   (pv_s2),
    .qv_o   (qv_s2),
    .e1_o   (e1_s2),
    .tv_o   (tv_s2),
    .vld_o  (vld2)
  );

  for (genvar k = 0; k < 3; k++) begin : g_dir
    assign dx[k] = (W+1)'(dir_q[k]);
  end

  // stages 3 and 4: det, unum and vnum
  rti_dot #(.W(W)) u_dot_det (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (e1_s2),
    .p_i   (pv_s2),
    .dot_o (det)
  );

  rti_dot #(.W(W)) u_dot_u (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (tv_s2),
    .p_i   (pv_s2),
    .dot_o (unum)
  );

  rti_dot #(.W(W)) u_dot_v (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (dx),
    .p_i   (qv_s2),
    .dot_o (vnum)
  );

  // valid bits for the dot stages and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q    <= 1'b0;
      vld4_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld3_q    <= vld2;
      vld4_q    <= vld3_q;
      out_vld_q <= vld4_q;
    end
  end

  // stage 5: ordered tests, det first, then u, then v
  assign th_ext = $signed(DW'(th_q));
  assign uv_sum = (DW+1)'(unum) + (DW+1)'(vnum);

  always_comb begin
    if (det < th_ext) begin
      reason_d = MISS_DET;
    end else if (unum[DW-1] || (det < unum)) begin
      reason_d = MISS_U;
    end else if (vnum[DW-1] || ((DW+1)'(det) < uv_sum)) begin
      reason_d = MISS_V;
    end else begin
      reason_d = MISS_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      reason_q <= reason_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'b0, reason_q, (reason_q == MISS_NONE)};

  // checks
  `include "ray_triangle_intersect_assert.svh"

  `RTI_ASSERT_NEXT(a_accept_enters, s_axis_tvalid_i && s_axis_tready_o, vld1)
  `RTI_ASSERT_IMPL(a_stall_blocks_input, out_vld_q && !m_axis_tready_i, !s_axis_tready_o)
  `RTI_ASSERT_IMPL(a_hit_matches_reason, m_axis_tvalid_o, m_axis_tdata_o[0] == (m_axis_tdata_o[2:1] == MISS_NONE))

endmodule

[tb/tb_ray_triangle_intersect.sv]
// ----------------------------------------------------------------------------
// tb_ray_triangle_intersect
// Triangle stream checked against the ray held in the cfg registers. A local
// predictor works out det, unum and vnum exactly at 128 bits and gives the
// expected hit flag and miss reason for every accepted triangle. The run
// covers directed geometry, extreme and random ray settings, random stalls
// on both sides, a long output hold-off and a full drain in mid-stream.
// ----------------------------------------------------------------------------
module tb_ray_triangle_intersect;
  import rti_pkg::*;

  localparam int COORD_W     = 24;
  localparam int TDATA_W     = ((9 * COORD_W + 7) / 8) * 8;
  localparam int LATENCY     = 5;
  localparam int STALL_LIMIT = 2000;
  localparam longint ONE     = 65536;
  localparam longint MAXC    = 8388607;
  localparam longint MINC    = -8388608;
  localparam logic [THRESH_W-1:0] DET_TH_MAX = 41'h100_0000_0000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [8:0][COORD_W-1:0] tri_t;
  typedef logic signed [127:0] wide_t;
  typedef struct packed {
    wide_t x;
    wide_t y;
    wide_t z;
  } vec3_t;
  typedef struct packed {
    logic  hit;
    miss_e reason;
  } verdict_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [THRESH_W-1:0]  cfg_data_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  // vertex0_x, vertex0_y, vertex0_z, vertex1_x .. vertex2_z
  logic [TDATA_W-1:0]   s_axis_tdata_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  // hit, miss_reason
  logic [7:0]           m_axis_tdata_o;

  // shadow of the ray registers
  coord_t              ray_org [3];
  coord_t              ray_dir [3];
  logic [THRESH_W-1:0] det_th;

  verdict_t pending_verdicts [$];
  verdict_t due;
  bit       idle_en;
  int       hold_left;
  int       stall_left;
  int       stall_cycles;
  int       fail_count;
  int       triangles_sent;
  int       ray_settings;
  int       reason_seen [4];

  ray_triangle_intersect #(
    .COORD_WIDTH(COORD_W),
    .FRAC_BITS  (16)
  ) i_dut (.*);

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // hit predictor
  // ---------------------------------------------------------------------------
  function automatic vec3_t to_vec(coord_t a, coord_t b, coord_t c);
    vec3_t v;
    v.x = a;
    v.y = b;
    v.z = c;
    return v;
  endfunction

  function automatic vec3_t diff3(vec3_t a, vec3_t b);
    vec3_t c;
    c.x = a.x - b.x;
    c.y = a.y - b.y;
    c.z = a.z - b.z;
    return c;
  endfunction

  function automatic vec3_t cross3(vec3_t a, vec3_t b);
    vec3_t c;
    c.x = a.y * b.z - a.z * b.y;
    c.y = a.z * b.x - a.x * b.z;
    c.z = a.x * b.y - a.y * b.x;
    return c;
  endfunction

  function automatic wide_t dot3(vec3_t a, vec3_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic verdict_t predict_verdict(tri_t t);
    vec3_t    v0, e1, e2, dr, tv, pv, qv;
    wide_t    det, unum, vnum, uv, th;
    verdict_t r;
    v0   = to_vec(t[0], t[1], t[2]);
    e1   = diff3(to_vec(t[3], t[4], t[5]), v0);
    e2   = diff3(to_vec(t[6], t[7], t[8]), v0);
    dr   = to_vec(ray_dir[0], ray_dir[1], ray_dir[2]);
    tv   = diff3(to_vec(ray_org[0], ray_org[1], ray_org[2]), v0);
    pv   = cross3(dr, e2);
    det  = dot3(e1, pv);
    unum = dot3(tv, pv);
    qv   = cross3(tv, e1);
    vnum = dot3(dr, qv);
    uv   = unum + vnum;
    th   = '0;
    th[THRESH_W-1:0] = det_th;
    // det first, then u, then v; first failing test names the reason
    if (det < th) begin
      r.reason = MISS_DET;
    end else if (unum < 0 || det < unum) begin
      r.reason = MISS_U;
    end else if (vnum < 0 || det < uv) begin
      r.reason = MISS_V;
    end else begin
      r.reason = MISS_NONE;
    end
    r.hit = (r.reason == MISS_NONE);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // monitors
  // ---------------------------------------------------------------------------
  // accepted triangle: queue its verdict
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      pending_verdicts.push_back(predict_verdict(s_axis_tdata_i[9*COORD_W-1:0]));
      triangles_sent++;
    end
  end

  // accepted result: compare with the oldest verdict
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with no triangle outstanding, tdata %0h", m_axis_tdata_o);
        fail_count++;
      end else begin
        due = pending_verdicts.pop_front();
        reason_seen[due.reason]++;
        if (m_axis_tdata_o[0] !== due.hit) begin
          $error("hit mismatch: expected %0d, actual %0d", due.hit, m_axis_tdata_o[0]);
          fail_count++;
        end
        if (m_axis_tdata_o[2:1] !== due.reason) begin
          $error("miss_reason mismatch: expected %0d, actual %0d",
                 due.reason, m_axis_tdata_o[2:1]);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted request
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result receiver: long hold-off on request, else random stall bursts
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 14);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic coord_t clamp_coord(longint v);
    if (v > MAXC) return coord_t'(MAXC);
    if (v < MINC) return coord_t'(MINC);
    return coord_t'(v);
  endfunction

  function automatic tri_t tri_of(longint x0, longint y0, longint z0,
                                  longint x1, longint y1, longint z1,
                                  longint x2, longint y2, longint z2);
    tri_t t;
    t[0] = clamp_coord(x0);
    t[1] = clamp_coord(y0);
    t[2] = clamp_coord(z0);
    t[3] = clamp_coord(x1);
    t[4] = clamp_coord(y1);
    t[5] = clamp_coord(z1);
    t[6] = clamp_coord(x2);
    t[7] = clamp_coord(y2);
    t[8] = clamp_coord(z2);
    return t;
  endfunction

  function automatic longint rand_signed(int unsigned m);
    return longint'($urandom_range(0, 2 * m)) - longint'(m);
  endfunction

  function automatic longint rand_component(int unsigned lo_exp, int unsigned hi_exp);
    if ($urandom_range(0, 5) == 0) return 0;
    return rand_signed(1 << $urandom_range(lo_exp, hi_exp));
  endfunction

  function automatic logic [THRESH_W-1:0] rand_threshold();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return DET_TH_RESET;
      2: return DET_TH_MAX;
      3: return {1'b0, 8'($urandom), 32'($urandom)};
      4: return THRESH_W'($urandom_range(0, 1 << 22));
      default: return THRESH_W'($urandom_range(0, 1 << 30));
    endcase
  endfunction

  // coordinate register word with junk above the coordinate width
  function automatic logic [THRESH_W-1:0] coord_word(longint v);
    return {17'($urandom), coord_t'(v)};
  endfunction

  // mostly triangles placed on the ray line, some pure noise
  function automatic tri_t random_triangle();
    tri_t        t;
    longint      ctr;
    longint      a;
    longint      b;
    longint      k;
    int unsigned span;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      for (int i = 0; i < 9; i++) t[i] = COORD_W'($urandom());
      return t;
    end
    k    = longint'($urandom_range(0, 4)) - 1;
    span = 1 << $urandom_range(0, 20);
    for (int i = 0; i < 3; i++) begin
      ctr = longint'(ray_org[i]) + k * longint'(ray_dir[i]);
      a   = rand_signed(span);
      b   = rand_signed(span);
      t[i]     = clamp_coord(ctr + a);
      t[3 + i] = clamp_coord(ctr + b);
      // centroid on the ray, or a free third vertex
      t[6 + i] = (pick < 6) ? clamp_coord(ctr - a - b) : clamp_coord(ctr + rand_signed(span));
    end
    return t;
  endfunction

  // one triangle request, optionally after a random gap
  task automatic send_triangle(tri_t t);
    if (idle_en && $urandom_range(0, 15) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= TDATA_W'(t);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THRESH_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_ORIGIN_X: ray_org[0] = data[COORD_W-1:0];
      REG_ORIGIN_Y: ray_org[1] = data[COORD_W-1:0];
      REG_ORIGIN_Z: ray_org[2] = data[COORD_W-1:0];
      REG_DIR_X:    ray_dir[0] = data[COORD_W-1:0];
      REG_DIR_Y:    ray_dir[1] = data[COORD_W-1:0];
      REG_DIR_Z:    ray_dir[2] = data[COORD_W-1:0];
      REG_DET_TH:   det_th     = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic program_ray(longint ox, longint oy, longint oz,
                             longint dx, longint dy, longint dz,
                             logic [THRESH_W-1:0] th);
    write_reg(REG_ORIGIN_X, coord_word(ox));
    write_reg(REG_ORIGIN_Y, coord_word(oy));
    write_reg(REG_ORIGIN_Z, coord_word(oz));
    write_reg(REG_DIR_X, coord_word(dx));
    write_reg(REG_DIR_Y, coord_word(dy));
    write_reg(REG_DIR_Z, coord_word(dz));
    write_reg(REG_DET_TH, th);
    cfg_valid_i <= 1'b0;
    ray_settings++;
  endtask

  task automatic program_random_ray();
    program_ray(rand_component(0, 20), rand_component(0, 20), rand_component(0, 20),
                rand_component(8, 18), rand_component(8, 18), rand_component(8, 18),
                rand_threshold());
  endtask

  task automatic send_extreme_triangles();
    send_triangle({9{24'h7FFFFF}});
    send_triangle({9{24'h800000}});
    send_triangle({{3{24'h000000}}, {3{24'h7FFFFF}}, {3{24'h800000}}});
    send_triangle({{4{24'h555555, 24'hAAAAAA}}, 24'h555555});
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // default ray: origin at zero looking along +z, threshold about 1e-9
  task automatic test_reset_config();
    send_triangle(tri_of(-ONE, -ONE, ONE, 0, ONE, ONE, ONE, -ONE, ONE));
    // back-facing winding
    send_triangle(tri_of(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE));
    // edge-on, det zero
    send_triangle(tri_of(0, -ONE, 0, 0, ONE, 0, 0, 0, ONE));
    // off to each side of the ray
    send_triangle(tri_of(ONE, -ONE, ONE, 2 * ONE, ONE, ONE, 3 * ONE, -ONE, ONE));
    send_triangle(tri_of(-3 * ONE, -ONE, ONE, -2 * ONE, ONE, ONE, -ONE, -ONE, ONE));
    send_triangle(tri_of(-ONE, 2 * ONE, ONE, 0, 4 * ONE, ONE, ONE, 2 * ONE, ONE));
    send_triangle(tri_of(-ONE, -4 * ONE, ONE, 0, -2 * ONE, ONE, ONE, -4 * ONE, ONE));
    // ray through a vertex
    send_triangle(tri_of(0, 0, ONE, ONE, 2 * ONE, ONE, 2 * ONE, 0, ONE));
    // behind the origin
    send_triangle(tri_of(-ONE, -ONE, -ONE, 0, ONE, -ONE, ONE, -ONE, -ONE));
    // tiny triangles just below and above the threshold
    send_triangle(tri_of(-1, -1, ONE, 0, 1, ONE, 1, -1, ONE));
    send_triangle(tri_of(-2, -2, ONE, 0, 2, ONE, 2, -2, ONE));
    send_extreme_triangles();
    drain_results();
  endtask

  // zero threshold: det of zero passes, u decides on unum alone
  task automatic test_zero_threshold();
    write_reg(REG_DET_TH, '0);
    cfg_valid_i <= 1'b0;
    send_triangle(tri_of(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
    send_triangle(tri_of(ONE, -ONE, 0, ONE, ONE, 0, ONE, 0, ONE));
    send_triangle(tri_of(-ONE, -ONE, 0, -ONE, ONE, 0, -ONE, 0, ONE));
    drain_results();
  endtask

  task automatic test_config_extremes();
    program_ray(MAXC, MAXC, MAXC, MINC, MINC, MINC, DET_TH_MAX);
    send_extreme_triangles();
    drain_results();
    program_ray(MINC, MINC, MINC, MAXC, MAXC, MAXC, '0);
    send_extreme_triangles();
    drain_results();
  endtask

  task automatic test_random_rays();
    for (int p = 0; p < 7; p++) begin
      program_random_ray();
      repeat (150) send_triangle(random_triangle());
      drain_results();
    end
  endtask

  // output held off long enough for the pipe to fill and stall the input
  task automatic test_backpressure();
    program_random_ray();
    hold_left = 120;
    repeat (60) send_triangle(random_triangle());
    drain_results();
  endtask

  // sender pauses mid-stream until every result is back
  task automatic test_drain_pause();
    program_random_ray();
    repeat (40) send_triangle(random_triangle());
    drain_results();
    repeat (40) send_triangle(random_triangle());
    drain_results();
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    program_random_ray();
    repeat (100) send_triangle(random_triangle());
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_ORIGIN_X;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    idle_en         = 1'b1;
    ray_org         = '{0, 0, 0};
    ray_dir         = '{0, 0, coord_t'(ONE)};
    det_th          = DET_TH_RESET;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_config();
    test_zero_threshold();
    test_config_extremes();
    test_random_rays();
    test_backpressure();
    test_drain_pause();
    test_back_to_back();

    drain_results();
    repeat (2 * LATENCY) @(posedge clk_i);
    if (pending_verdicts.size() != 0) begin
      $error("%0d results never arrived", pending_verdicts.size());
      fail_count++;
    end
    $display("checked %0d triangles under %0d ray settings plus reset defaults",
             triangles_sent, ray_settings);
    $display("outcomes: %0d hits, %0d det culled, %0d u outside, %0d v outside",
             reason_seen[MISS_NONE], reason_seen[MISS_DET], reason_seen[MISS_U],
             reason_seen[MISS_V]);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
